[rtl/nws_pkg.sv]
package nws_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 24;
  localparam int PT_W       = 3 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 2;

  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
    logic [COUNT_W-1:0] point_count;
    logic               overflow_seen;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

endpackage

[rtl/nws_ram.sv]
module nws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/nearest_waypoint_search_top.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_data  (in_t: mode, pos_x, pos_y, pos_z)
// out      output     out_valid / out_stall out_data (out_t: nearest_index, point_count,
//                                                     overflow_seen)
//
// A query over n >= 2 stored points reads one point from the waypoint RAM per cycle,
// then a four-stage distance pipeline drains.
// A query over fewer than two points skips the scan and goes straight to the result hand-off.
// rst_n (synchronous) empties the table and clears the overflow flag; RAM is not cleared.
// in_stall is high during a query; a waiting result does not block clear or append.
module nearest_waypoint_search_top
  import nws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  in_t               pose_r;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic [SUM_W-1:0]  best_d_r, best_d_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r;

  // scan pipeline
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              v1_nxt;
  logic [ADDR_W-1:0] tag1_r, tag2_r, tag3_r, tag4_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [2*DIFF_W-1:0] px_prod, py_prod, pz_prod;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]  sum_r;

  logic              in_acc;
  logic              wr_en, rd_en;
  logic [PT_W-1:0]   rd_data;
  logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic              last_pt;
  logic              take_pt;
  logic              out_load;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Appends only happen in idle and reads only during a scan, so the stall on
  // the input side keeps RAM write and read from touching the same entry.
  assign wr_en = in_acc && (in_data.mode == MODE_APPEND) && (cnt_r < CNT_W'(MAX_POINTS));
  assign rd_en = (state_r == S_SCAN) && (issue_r < cnt_r);

  nws_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt_r[ADDR_W-1:0]),
    .wr_data({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
    .rd_en  (rd_en),
    .rd_addr(issue_r[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  assign rd_x = rd_data[3*COORD_W-1:2*COORD_W];
  assign rd_y = rd_data[2*COORD_W-1:COORD_W];
  assign rd_z = rd_data[COORD_W-1:0];

  assign dx_nxt = {rd_x[COORD_W-1], rd_x} - {pose_r.pos_x[COORD_W-1], pose_r.pos_x};
  assign dy_nxt = {rd_y[COORD_W-1], rd_y} - {pose_r.pos_y[COORD_W-1], pose_r.pos_y};
  assign dz_nxt = {rd_z[COORD_W-1], rd_z} - {pose_r.pos_z[COORD_W-1], pose_r.pos_z};

  // |diff| < 2^24, so each square fits SQ_W bits
  assign px_prod = dx_r * dx_r;
  assign py_prod = dy_r * dy_r;
  assign pz_prod = dz_r * dz_r;

  assign take_pt  = v4_r && ((tag4_r == '0) || (sum_r < best_d_r));
  assign last_pt  = v4_r && (tag4_r == ADDR_W'(cnt_r - CNT_W'(1)));
  assign out_load = (state_r == S_WAIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    issue_nxt     = issue_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    v1_nxt        = rd_en;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            MODE_CLEAR: begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            MODE_APPEND: begin
              if (wr_en) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            MODE_QUERY: begin
              issue_nxt    = '0;
              best_idx_nxt = '0;
              if (cnt_r < CNT_W'(2)) begin
                state_nxt = S_WAIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (take_pt) begin
          best_idx_nxt = tag4_r;
          best_d_nxt   = sum_r;
        end
        if (last_pt) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      issue_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      issue_r     <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == MODE_QUERY)) begin
      pose_r <= in_data;
    end
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    tag1_r     <= issue_r[ADDR_W-1:0];
    tag2_r     <= tag1_r;
    tag3_r     <= tag2_r;
    tag4_r     <= tag3_r;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    sx_r       <= px_prod[SQ_W-1:0];
    sy_r       <= py_prod[SQ_W-1:0];
    sz_r       <= pz_prod[SQ_W-1:0];
    sum_r      <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    if (out_load) begin
      out_r.nearest_index <= INDEX_W'(best_idx_r);
      out_r.point_count   <= COUNT_W'(cnt_r);
      out_r.overflow_seen <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WAIT))
    else $error("result raised outside of result hand-off");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("stored count beyond capacity");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> ($past(cnt_r) == CNT_W'(MAX_POINTS)))
    else $error("overflow set while table not full");

  a_scan_tag: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && v4_r) |-> (CNT_W'(tag4_r) < cnt_r))
    else $error("scan reached an entry beyond the stored count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !wr_en)
    else $error("table write during query");

endmodule
